@@ src/bpa_pkg.sv @@
// Package for the buddy page allocator: sizes, node entry layout and link helpers.
// No dependencies; used by the interfaces, the RAM users and the top level.
package bpa_pkg;

  localparam int unsigned PAGES     = 1024;
  localparam int unsigned ORDERS    = 11;
  localparam int unsigned TOP_ORDER = ORDERS - 1;
  localparam int unsigned TOP_SIZE  = 1 << TOP_ORDER;

  // Fixed item field widths
  localparam int unsigned NEED_W = 11;
  localparam int unsigned BORD_W = 4;

  localparam int unsigned PAGE_W = $clog2(PAGES);
  localparam int unsigned LINK_W = PAGE_W + 1;
  // Order codes; all ones is reserved for a page that is not a list head
  localparam int unsigned ORD_W  = $clog2(ORDERS + 1);
  localparam int unsigned WANT_W = $clog2(NEED_W + 2);

  localparam logic [LINK_W-1:0] NIL       = '1;
  localparam logic [ORD_W-1:0]  ORD_BUDDY = '1;

  // Node entry: tag (alloc flag plus order) and forward link
  typedef struct packed {
    logic              alloc;
    logic [ORD_W-1:0]  ord;
    logic [LINK_W-1:0] next;
  } node_t;

  localparam int unsigned NODE_W = $bits(node_t);

  function automatic logic is_nil(input logic [LINK_W-1:0] l);
    return l[LINK_W-1];
  endfunction

endpackage

@@ src/bpa_if.sv @@
// Handshake channels for request and response items of the buddy page allocator.
// Depends on bpa_pkg for field widths.
interface bpa_req_if;
  import bpa_pkg::*;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [NEED_W-1:0] need_pages;
  logic [PAGE_W-1:0] page_index;
  modport source (output valid, kind, need_pages, page_index, input ready);
  modport sink   (input valid, kind, need_pages, page_index, output ready);
endinterface

interface bpa_rsp_if;
  import bpa_pkg::*;
  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] start_page;
  logic [BORD_W-1:0] block_order;
  logic              status;
  modport source (output valid, start_page, block_order, status, input ready);
  modport sink   (input valid, start_page, block_order, status, output ready);
endinterface

@@ src/bpa_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ src/buddy_page_allocator_core.sv @@
// Buddy page allocator: one request item at a time, one response item each.
// Allocate: a refused item goes straight to the response; otherwise the block pops a list
// head and splits it down to the requested order. Free: a refused item goes straight to the
// response; otherwise the block merges with free buddies and pushes onto the target list.
// A pending unaccepted response holds the next one in S_RESP.
// After reset a clearing pass builds the top-order free lists.
module buddy_page_allocator_core (
  input  logic     clk_i,
  input  logic     rst_ni,
  bpa_req_if.sink  in_i,
  bpa_rsp_if.source out_o
);
  import bpa_pkg::*;

  typedef enum logic [13:0] {
    S_INIT   = 14'b00000000000001,
    S_IDLE   = 14'b00000000000010,
    S_AFIND  = 14'b00000000000100,
    S_AUNL   = 14'b00000000001000,
    S_ASPLIT = 14'b00000000010000,
    S_FRD    = 14'b00000000100000,
    S_FCHK   = 14'b00000001000000,
    S_MRD    = 14'b00000010000000,
    S_MCHK   = 14'b00000100000000,
    S_MUNL   = 14'b00001000000000,
    S_PUSH   = 14'b00010000000000,
    S_PUSH2  = 14'b00100000000000,
    S_RESP   = 14'b01000000000000,
    S_SPARE  = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  logic [PAGE_W-1:0] cnt_q, cnt_d;
  logic [LINK_W-1:0] head_q [ORDERS];
  logic [LINK_W-1:0] head_d [ORDERS];

  // Request and working registers
  logic              kind_q, kind_d;
  logic [NEED_W-1:0] need_q, need_d;
  logic [PAGE_W-1:0] pidx_q, pidx_d;
  logic [PAGE_W-1:0] h_q, h_d;
  logic [PAGE_W-1:0] b_q, b_d;
  logic [LINK_W-1:0] hd_q, hd_d;
  logic [ORD_W-1:0]  o_q, o_d;
  logic [ORD_W-1:0]  want_q, want_d;

  // Result staging and output register
  logic [PAGE_W-1:0] res_start_q, res_start_d;
  logic [ORD_W-1:0]  res_ord_q, res_ord_d;
  logic              res_stat_q, res_stat_d;
  logic              ov_q, ov_d;
  logic [PAGE_W-1:0] os_q, os_d;
  logic [BORD_W-1:0] oo_q, oo_d;
  logic              ost_q, ost_d;

  // RAM ports
  logic              n_we, p_we;
  logic [PAGE_W-1:0] n_waddr, n_raddr, p_waddr, p_raddr;
  node_t             n_wdata, n_rdata;
  logic [LINK_W-1:0] p_wdata, p_rdata;
  logic [NODE_W-1:0] n_rbits;

  assign n_rdata = node_t'(n_rbits);

  bpa_ram #(.WIDTH(NODE_W), .DEPTH(PAGES)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (n_we),
    .waddr_i (n_waddr),
    .wdata_i (n_wdata),
    .raddr_i (n_raddr),
    .rdata_o (n_rbits)
  );

  bpa_ram #(.WIDTH(LINK_W), .DEPTH(PAGES)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  // Requested order: count of powers of two below the page count
  logic [WANT_W-1:0] want_c;
  always_comb begin
    want_c = '0;
    for (int k = 0; k <= NEED_W - 1; k++) begin
      if (need_q > (NEED_W'(1) << k)) begin
        want_c = want_c + WANT_W'(1);
      end
    end
  end

  // Lowest non-empty list at or above the requested order
  logic             found_c;
  logic [ORD_W-1:0] fo_c;
  always_comb begin
    found_c = 1'b0;
    fo_c    = '0;
    for (int k = TOP_ORDER; k >= 0; k--) begin
      if ((WANT_W'(k) >= want_c) && !is_nil(head_q[k])) begin
        found_c = 1'b1;
        fo_c    = ORD_W'(k);
      end
    end
  end

  // Buddy address for the merge walk
  logic [LINK_W-1:0] bud_c;
  assign bud_c = {1'b0, h_q} ^ (LINK_W'(1) << o_q);

  // Clearing pass values
  logic [LINK_W-1:0] init_next, init_prev;
  logic              init_head;
  assign init_head = ((LINK_W'(cnt_q) & LINK_W'(TOP_SIZE - 1)) == '0);
  assign init_next = (LINK_W'(cnt_q) + LINK_W'(TOP_SIZE) < LINK_W'(PAGES)) ?
                     LINK_W'(cnt_q) + LINK_W'(TOP_SIZE) : NIL;
  assign init_prev = (cnt_q == '0) ? NIL : LINK_W'(cnt_q) - LINK_W'(TOP_SIZE);

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = ov_q;
  assign out_o.start_page  = os_q;
  assign out_o.block_order = oo_q;
  assign out_o.status      = ost_q;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    head_d      = head_q;
    kind_d      = kind_q;
    need_d      = need_q;
    pidx_d      = pidx_q;
    h_d         = h_q;
    b_d         = b_q;
    hd_d        = hd_q;
    o_d         = o_q;
    want_d      = want_q;
    res_start_d = res_start_q;
    res_ord_d   = res_ord_q;
    res_stat_d  = res_stat_q;
    ov_d        = ov_q;
    os_d        = os_q;
    oo_d        = oo_q;
    ost_d       = ost_q;
    n_we        = 1'b0;
    n_waddr     = h_q;
    n_wdata     = '{alloc: 1'b0, ord: ORD_BUDDY, next: NIL};
    n_raddr     = bud_c[PAGE_W-1:0];
    p_we        = 1'b0;
    p_waddr     = h_q;
    p_wdata     = NIL;
    p_raddr     = bud_c[PAGE_W-1:0];

    if (ov_q && out_o.ready) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      S_INIT: begin
        n_we    = 1'b1;
        n_waddr = cnt_q;
        p_we    = 1'b1;
        p_waddr = cnt_q;
        if (init_head) begin
          n_wdata = '{alloc: 1'b0, ord: ORD_W'(TOP_ORDER), next: init_next};
          p_wdata = init_prev;
        end
        cnt_d = cnt_q + PAGE_W'(1);
        if (cnt_q == PAGE_W'(PAGES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_i.valid) begin
          kind_d  = in_i.kind;
          need_d  = in_i.need_pages;
          pidx_d  = in_i.page_index;
          state_d = in_i.kind ? S_FRD : S_AFIND;
        end
      end
      S_AFIND: begin
        n_raddr = head_q[fo_c][PAGE_W-1:0];
        if ((want_c > WANT_W'(TOP_ORDER)) || !found_c) begin
          res_start_d = '0;
          res_ord_d   = '0;
          res_stat_d  = 1'b1;
          state_d     = S_RESP;
        end else begin
          h_d     = head_q[fo_c][PAGE_W-1:0];
          o_d     = fo_c;
          want_d  = ORD_W'(want_c);
          state_d = S_AUNL;
        end
      end
      S_AUNL: begin
        // Pop the head: successor becomes head with no predecessor
        head_d[o_q] = n_rdata.next;
        if (!is_nil(n_rdata.next)) begin
          p_we    = 1'b1;
          p_waddr = n_rdata.next[PAGE_W-1:0];
          p_wdata = NIL;
        end
        state_d = S_ASPLIT;
      end
      S_ASPLIT: begin
        n_we = 1'b1;
        if (o_q > want_q) begin
          // Upper half goes onto a list that is known to be empty
          n_waddr           = h_q + (PAGE_W'(1) << (o_q - ORD_W'(1)));
          n_wdata           = '{alloc: 1'b0, ord: o_q - ORD_W'(1), next: NIL};
          p_we              = 1'b1;
          p_waddr           = n_waddr;
          p_wdata           = NIL;
          head_d[o_q - ORD_W'(1)] = {1'b0, n_waddr};
          o_d               = o_q - ORD_W'(1);
        end else begin
          n_waddr     = h_q;
          n_wdata     = '{alloc: 1'b1, ord: want_q, next: NIL};
          res_start_d = h_q;
          res_ord_d   = want_q;
          res_stat_d  = 1'b0;
          state_d     = S_RESP;
        end
      end
      S_FRD: begin
        n_raddr = pidx_q;
        if ({1'b0, pidx_q} < LINK_W'(PAGES)) begin
          state_d = S_FCHK;
        end else begin
          res_start_d = pidx_q;
          res_ord_d   = '0;
          res_stat_d  = 1'b1;
          state_d     = S_RESP;
        end
      end
      S_FCHK: begin
        if (!n_rdata.alloc) begin
          res_start_d = pidx_q;
          res_ord_d   = '0;
          res_stat_d  = 1'b1;
          state_d     = S_RESP;
        end else begin
          n_we    = 1'b1;
          n_waddr = pidx_q;
          h_d     = pidx_q;
          o_d     = (n_rdata.ord > ORD_W'(TOP_ORDER)) ? ORD_W'(TOP_ORDER) : n_rdata.ord;
          state_d = S_MRD;
        end
      end
      S_MRD: begin
        b_d = bud_c[PAGE_W-1:0];
        if ((o_q < ORD_W'(TOP_ORDER)) && (bud_c < LINK_W'(PAGES))) begin
          state_d = S_MCHK;
        end else begin
          state_d = S_PUSH;
        end
      end
      S_MCHK: begin
        if (!n_rdata.alloc && (n_rdata.ord == o_q)) begin
          // Unlink the free buddy from its list
          if (!is_nil(p_rdata)) begin
            n_we    = 1'b1;
            n_waddr = p_rdata[PAGE_W-1:0];
            n_wdata = '{alloc: 1'b0, ord: o_q, next: n_rdata.next};
          end else begin
            head_d[o_q] = n_rdata.next;
          end
          if (!is_nil(n_rdata.next)) begin
            p_we    = 1'b1;
            p_waddr = n_rdata.next[PAGE_W-1:0];
            p_wdata = p_rdata;
          end
          state_d = S_MUNL;
        end else begin
          state_d = S_PUSH;
        end
      end
      S_MUNL: begin
        n_we    = 1'b1;
        n_waddr = b_q;
        h_d     = h_q & ~(PAGE_W'(1) << o_q);
        o_d     = o_q + ORD_W'(1);
        state_d = S_MRD;
      end
      S_PUSH: begin
        n_we        = 1'b1;
        n_waddr     = h_q;
        n_wdata     = '{alloc: 1'b0, ord: o_q, next: head_q[o_q]};
        p_we        = 1'b1;
        p_waddr     = h_q;
        p_wdata     = NIL;
        head_d[o_q] = {1'b0, h_q};
        hd_d        = head_q[o_q];
        res_start_d = h_q;
        res_ord_d   = o_q;
        res_stat_d  = 1'b0;
        state_d     = is_nil(head_q[o_q]) ? S_RESP : S_PUSH2;
      end
      S_PUSH2: begin
        p_we    = 1'b1;
        p_waddr = hd_q[PAGE_W-1:0];
        p_wdata = {1'b0, h_q};
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!ov_q || out_o.ready) begin
          ov_d    = 1'b1;
          os_d    = res_start_q;
          oo_d    = BORD_W'(res_ord_q);
          ost_d   = res_stat_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
      for (int k = 0; k < ORDERS; k++) begin
        head_q[k] <= (k == TOP_ORDER) ? LINK_W'(0) : NIL;
      end
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
      head_q  <= head_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    need_q      <= need_d;
    pidx_q      <= pidx_d;
    h_q         <= h_d;
    b_q         <= b_d;
    hd_q        <= hd_d;
    o_q         <= o_d;
    want_q      <= want_d;
    res_start_q <= res_start_d;
    res_ord_q   <= res_ord_d;
    res_stat_q  <= res_stat_d;
    os_q        <= os_d;
    oo_q        <= oo_d;
    ost_q       <= ost_d;
  end

`ifndef SYNTH
  // An accepted item always leaves idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (state_q != S_IDLE))
    else $error("accepted item did not start work");

  // Splitting never goes below the requested order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ASPLIT) |-> (o_q >= want_q))
    else $error("split below requested order");

  // Merge check only happens below the top order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MCHK) |-> (o_q < ORD_W'(TOP_ORDER)))
    else $error("merge check at top order");

  // A free item request decision follows a free request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FCHK) |-> kind_q)
    else $error("free path entered on allocate item");
`endif

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for buddy_page_allocator_core: allocate/free items with a built-in
// buddy-allocator predictor, random handshake gaps on both channels.
// Depends on bpa_pkg, bpa_if and the allocator RTL.
module tb_top;
  import bpa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAG_BUD   = 253;
  localparam int TAG_AHEAD = 254;
  localparam int TAG_ALLOC = 255;
  localparam int NONE      = -1;
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;
  localparam logic ST_OK      = 1'b0;
  localparam logic ST_REFUSED = 1'b1;
  localparam int N_RANDOM  = 1800;

  typedef struct packed {
    logic       kind;
    logic [10:0] need;
    logic [9:0]  pidx;
  } req_t;

  typedef struct packed {
    logic [9:0] start;
    logic [3:0] ord;
    logic       status;
  } rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bpa_req_if req_ch ();
  bpa_rsp_if rsp_ch ();

  buddy_page_allocator_core uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_ch.sink),
    .out_o (rsp_ch.source)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow allocator state
  int tag_mem [PAGES];
  int ord_mem [PAGES];
  int prv_mem [PAGES];
  int nxt_mem [PAGES];
  int head_of [ORDERS];
  int cnt_of  [ORDERS];

  rsp_t expected_rsp[$];
  int   owned_blocks[$];
  int   n_err = 0;
  int   n_rsp = 0;
  int   n_alloc_ok = 0;
  int   n_free_ok = 0;
  int   n_refused = 0;

  function automatic void list_push(int o, int p);
    tag_mem[p] = o;
    prv_mem[p] = NONE;
    nxt_mem[p] = head_of[o];
    if (head_of[o] != NONE) prv_mem[head_of[o]] = p;
    head_of[o] = p;
    cnt_of[o]++;
  endfunction

  function automatic void list_unlink(int o, int p);
    int pv;
    int nx;
    pv = prv_mem[p];
    nx = nxt_mem[p];
    if (pv != NONE) nxt_mem[pv] = nx;
    else head_of[o] = nx;
    if (nx != NONE) prv_mem[nx] = pv;
    prv_mem[p] = NONE;
    nxt_mem[p] = NONE;
    cnt_of[o]--;
  endfunction

  function automatic void pool_reset();
    int p;
    int o;
    for (int i = 0; i < ORDERS; i++) begin
      head_of[i] = NONE;
      cnt_of[i] = 0;
    end
    for (int i = 0; i < PAGES; i++) begin
      tag_mem[i] = TAG_BUD;
      ord_mem[i] = 0;
      prv_mem[i] = NONE;
      nxt_mem[i] = NONE;
    end
    p = 0;
    while (p < PAGES) begin
      o = TOP_ORDER;
      while (o > 0 && (((p & ((1 << o) - 1)) != 0) || p + (1 << o) > PAGES)) o--;
      tag_mem[p] = o;
      p += 1 << o;
    end
    for (int q = PAGES; q > 0; q--)
      if (tag_mem[q-1] <= TOP_ORDER) list_push(tag_mem[q-1], q-1);
  endfunction

  // Predict the response of one request and update the shadow state
  function automatic rsp_t predict_alloc_free(req_t r);
    rsp_t res;
    int want;
    int o;
    int h;
    int b;
    res = '0;
    if (r.kind == KIND_ALLOC) begin
      want = 0;
      while (want < 31 && (1 << want) < int'(r.need)) want++;
      o = want;
      while (o <= TOP_ORDER && cnt_of[o] == 0) o++;
      if (want > TOP_ORDER || o > TOP_ORDER) begin
        res.status = ST_REFUSED;
      end else begin
        h = head_of[o];
        list_unlink(o, h);
        while (o > want) begin
          o--;
          list_push(o, h + (1 << o));
        end
        for (int i = 0; i < (1 << want); i++) tag_mem[h+i] = TAG_ALLOC;
        tag_mem[h] = TAG_AHEAD;
        ord_mem[h] = want;
        res.start = 10'(h);
        res.ord = 4'(want);
      end
    end else begin
      h = int'(r.pidx);
      if (h >= PAGES || tag_mem[h] != TAG_AHEAD) begin
        res.status = ST_REFUSED;
        res.start = r.pidx;
      end else begin
        o = ord_mem[h];
        if (o > TOP_ORDER) o = TOP_ORDER;
        ord_mem[h] = 0;
        for (int i = 1; i < (1 << o) && h + i < PAGES; i++) tag_mem[h+i] = TAG_BUD;
        tag_mem[h] = o;
        while (o < TOP_ORDER) begin
          b = h ^ (1 << o);
          if (b >= PAGES || tag_mem[b] != o) break;
          list_unlink(o, b);
          if (b < h) begin
            tag_mem[h] = TAG_BUD;
            h = b;
          end else begin
            tag_mem[b] = TAG_BUD;
          end
          o++;
          tag_mem[h] = o;
        end
        list_push(o, h);
        res.start = 10'(h);
        res.ord = 4'(o);
      end
    end
    return res;
  endfunction

  // Send one request; keep the owned-block list in step with the prediction
  task automatic send_req(req_t r, logic chk, rsp_t fixed);
    rsp_t p;
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
    // valid stays high across a zero gap, so it is never driven twice in one step
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind <= r.kind;
    req_ch.need_pages <= r.need;
    req_ch.page_index <= r.pidx;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    p = predict_alloc_free(r);
    if (chk && p != fixed) begin
      $display("table row disagrees with predictor: row %h pred %h", fixed, p);
      n_err++;
    end
    if (p.status == ST_OK) begin
      if (r.kind == KIND_ALLOC) owned_blocks.push_back(int'(p.start));
      else begin
        for (int i = 0; i < owned_blocks.size(); i++)
          if (owned_blocks[i] == int'(r.pidx)) begin
            owned_blocks.delete(i);
            break;
          end
      end
    end
    expected_rsp.push_back(p);
  endtask

  // Response side: random per-item ready stall, compare with oldest expectation
  initial begin
    rsp_t got;
    rsp_t exp_r;
    int w;
    rsp_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      w = $urandom_range(0, 13);
      if (w > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!(rsp_ch.valid && rsp_ch.ready)) @(posedge clk_i);
      got.start = rsp_ch.start_page;
      got.ord = rsp_ch.block_order;
      got.status = rsp_ch.status;
      n_rsp++;
      if (expected_rsp.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected response item %h", got);
      end else begin
        exp_r = expected_rsp.pop_front();
        if (got != exp_r) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch: exp start %0d ord %0d st %0b, got start %0d ord %0d st %0b",
                     exp_r.start, exp_r.ord, exp_r.status, got.start, got.ord, got.status);
        end
        if (exp_r.status == ST_REFUSED) n_refused++;
      end
    end
  end

  // Directed table: expected typed only for obvious rows
  typedef struct {
    logic kind;
    int   need;
    int   pidx;
    logic chk;
    rsp_t exp_r;
  } row_t;

  row_t dir_rows[$];

  function automatic row_t mk(logic k, int n, int p, logic c, int s, int o, logic st);
    row_t r;
    r.kind = k;
    r.need = n;
    r.pidx = p;
    r.chk = c;
    r.exp_r.start = 10'(s);
    r.exp_r.ord = 4'(o);
    r.exp_r.status = st;
    return r;
  endfunction

  initial begin
    req_t r;
    int k;
    req_ch.valid = 1'b0;
    req_ch.kind = KIND_ALLOC;
    req_ch.need_pages = '0;
    req_ch.page_index = '0;
    pool_reset();
    // After reset: one top block of all pages
    dir_rows.push_back(mk(KIND_FREE, 0, 0, 1, 0, 0, ST_REFUSED));      // free of free page
    dir_rows.push_back(mk(KIND_ALLOC, 2047, 0, 1, 0, 0, ST_REFUSED));  // above top order
    dir_rows.push_back(mk(KIND_ALLOC, 1025, 0, 1, 0, 0, ST_REFUSED));
    dir_rows.push_back(mk(KIND_ALLOC, 0, 1023, 1, 0, 0, ST_OK));       // zero pages -> order 0
    dir_rows.push_back(mk(KIND_FREE, 0, 1, 1, 1, 0, ST_REFUSED));      // free list head
    dir_rows.push_back(mk(KIND_ALLOC, 1, 0, 1, 1, 0, ST_OK));
    dir_rows.push_back(mk(KIND_ALLOC, 3, 0, 0, 0, 0, ST_OK));
    dir_rows.push_back(mk(KIND_FREE, 0, 5, 1, 5, 0, ST_REFUSED));      // interior page
    dir_rows.push_back(mk(KIND_FREE, 0, 1, 0, 0, 0, ST_OK));
    dir_rows.push_back(mk(KIND_FREE, 0, 1, 1, 1, 0, ST_REFUSED));      // double free
    dir_rows.push_back(mk(KIND_FREE, 0, 4, 0, 0, 0, ST_OK));
    dir_rows.push_back(mk(KIND_FREE, 0, 0, 1, 0, 10, ST_OK));          // merges to top
    dir_rows.push_back(mk(KIND_ALLOC, 1024, 0, 1, 0, 10, ST_OK));
    dir_rows.push_back(mk(KIND_ALLOC, 1, 0, 1, 0, 0, ST_REFUSED));     // pool empty
    dir_rows.push_back(mk(KIND_FREE, 0, 1023, 1, 1023, 0, ST_REFUSED));
    dir_rows.push_back(mk(KIND_FREE, 0, 0, 1, 0, 10, ST_OK));
    dir_rows.push_back(mk(KIND_ALLOC, 512, 0, 0, 0, 0, ST_OK));
    dir_rows.push_back(mk(KIND_ALLOC, 1, 0, 0, 0, 0, ST_OK));
    dir_rows.push_back(mk(KIND_ALLOC, 1024, 0, 1, 0, 0, ST_REFUSED));
    dir_rows.push_back(mk(KIND_FREE, 0, 512, 0, 0, 0, ST_OK));
    dir_rows.push_back(mk(KIND_FREE, 0, 0, 0, 0, 0, ST_OK));
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (dir_rows[i]) begin
      r.kind = dir_rows[i].kind;
      r.need = 11'(dir_rows[i].need);
      r.pidx = 10'(dir_rows[i].pidx);
      send_req(r, dir_rows[i].chk, dir_rows[i].exp_r);
    end
    // Random part: mostly valid alloc/free, some junk frees and odd sizes
    for (int n = 0; n < N_RANDOM; n++) begin
      k = $urandom_range(0, 99);
      r.pidx = 10'($urandom);
      r.need = 11'($urandom);
      if (k < 50) begin
        r.kind = KIND_ALLOC;
        case ($urandom_range(0, 9))
          0: r.need = 11'($urandom_range(0, 2047));
          1: r.need = 11'($urandom_range(65, 1024));
          default: r.need = 11'($urandom_range(0, 16));
        endcase
        if (owned_blocks.size() > 40) r.kind = KIND_FREE;
      end else begin
        r.kind = KIND_FREE;
      end
      if (r.kind == KIND_FREE && k < 92 && owned_blocks.size() > 0)
        r.pidx = 10'(owned_blocks[$urandom_range(0, owned_blocks.size() - 1)]);
      send_req(r, 1'b0, '0);
    end
    req_ch.valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("ran %0d request items, %0d responses; %0d refused or ignored",
             dir_rows.size() + N_RANDOM, n_rsp, n_refused);
    if (n_err == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", n_err);
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: covers the clearing pass plus ~1800 items
  initial begin
    #(8ns * 1000000);
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end
endmodule
